@@ rtl/core/pbz_pkg.sv @@
// Shared types, widths and codes of the parking distance buzzer.
// No dependencies; every module of the block imports this package.
`timescale 1ns / 1ps

package pbz_pkg;

	localparam int SAMPLE_W        = 12;
	localparam int SUM_W           = 16;
	localparam int AVG_W           = 12;
	localparam int THR_W           = 7;
	localparam int BEEP_W          = 8;
	localparam int TIMER_W         = 12;
	localparam int AVG_SAMPLES_DEF = 10;
	localparam int QUEUE_DEPTH     = 4;
	localparam int QPTR_W          = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W          = $clog2(QUEUE_DEPTH + 1);

	localparam logic [AVG_W-1:0]  AVG_MAX      = 12'd4095;
	localparam logic [THR_W-1:0]  THRESH_MAX   = 7'd99;
	localparam logic [THR_W-1:0]  THRESH_RESET = 7'd40;
	localparam logic [AVG_W-1:0]  FAR_RESET    = 12'd300;
	localparam logic [BEEP_W-1:0] BEEP_RESET   = 8'd50;

	// item kinds on the input channel
	localparam logic [1:0] MODE_SAMPLE = 2'd0;
	localparam logic [1:0] MODE_ROT    = 2'd1;
	localparam logic [1:0] MODE_TICK   = 2'd2;

	// command kinds handed from front to back
	localparam logic [1:0] CMD_NONE = 2'd0;
	localparam logic [1:0] CMD_AVG  = 2'd1;
	localparam logic [1:0] CMD_ROT  = 2'd2;
	localparam logic [1:0] CMD_TICK = 2'd3;

	// tone phases
	localparam logic [1:0] PH_SILENT = 2'd0;
	localparam logic [1:0] PH_STEADY = 2'd1;
	localparam logic [1:0] PH_ON     = 2'd2;
	localparam logic [1:0] PH_OFF    = 2'd3;

	// configuration register indexes (paddr[2])
	localparam logic REG_FAR  = 1'b0;
	localparam logic REG_BEEP = 1'b1;

	typedef struct packed {
		logic [1:0]       kind;
		logic             setting;
		logic             enable;
		logic             left;
		logic             right;
		logic [SUM_W-1:0] sum;
	} cmd_t;

	typedef struct packed {
		logic [AVG_W-1:0]  far_limit;
		logic [BEEP_W-1:0] beep_on;
	} cfg_t;

endpackage

@@ rtl/core/pbz_front.sv @@
// Front end: accepts input words, tracks mode and the running sample group.
// Depends on pbz_pkg; feeds pbz_fifo with one command per accepted word.
`timescale 1ns / 1ps

module pbz_front
	import pbz_pkg::*;
#(
	parameter int AVG_SAMPLES = AVG_SAMPLES_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [1:0]          mode,
	input  logic [SAMPLE_W-1:0] sample_cm,
	input  logic                rot_press,
	input  logic                rot_left,
	input  logic                rot_right,
	input  logic                buzzer_enable,
	input  logic                q_full,
	output logic                push,
	output cmd_t                push_cmd
);

	localparam int CNT_W = $clog2(AVG_SAMPLES + 1);

	logic             setting_q;
	logic [SUM_W-1:0] sum_q;
	logic [CNT_W-1:0] cnt_q;

	logic             setting_n;
	logic [SUM_W-1:0] sum_n;
	logic [CNT_W-1:0] cnt_n;
	logic [SUM_W-1:0] sum_add;
	logic [CNT_W-1:0] cnt_add;

	assign in_stall = q_full;
	assign push     = in_valid && !q_full;

	assign sum_add = sum_q + SUM_W'(sample_cm);
	assign cnt_add = cnt_q + CNT_W'(1);

	always_comb begin
		setting_n         = setting_q;
		sum_n             = sum_q;
		cnt_n             = cnt_q;
		push_cmd.kind     = CMD_NONE;
		push_cmd.enable   = buzzer_enable;
		push_cmd.left     = rot_left;
		push_cmd.right    = rot_right;
		push_cmd.sum      = sum_add;
		case (mode)
			MODE_SAMPLE: begin
				if (!setting_q) begin
					if (cnt_add == CNT_W'(AVG_SAMPLES)) begin
						push_cmd.kind = CMD_AVG;
						sum_n         = '0;
						cnt_n         = '0;
					end else begin
						sum_n = sum_add;
						cnt_n = cnt_add;
					end
				end
			end
			MODE_ROT: begin
				setting_n     = setting_q ^ rot_press;
				push_cmd.kind = CMD_ROT;
			end
			MODE_TICK: begin
				if (!setting_q) begin
					push_cmd.kind = CMD_TICK;
				end
			end
			default: begin
				push_cmd.kind = CMD_NONE;
			end
		endcase
		push_cmd.setting = setting_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			setting_q <= 1'b0;
			sum_q     <= '0;
			cnt_q     <= '0;
		end else if (push) begin
			setting_q <= setting_n;
			sum_q     <= sum_n;
			cnt_q     <= cnt_n;
		end
	end

endmodule

@@ rtl/core/pbz_fifo.sv @@
// Short command queue between front and back.
// Depends on pbz_pkg for cmd_t and the queue depth.
`timescale 1ns / 1ps

module pbz_fifo
	import pbz_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	output logic full,
	input  logic pop,
	output logic head_valid,
	output cmd_t head_cmd
);

	cmd_t              slot_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign full       = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign head_valid = (count_q != '0);
	assign head_cmd   = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + QCNT_W'(1);
				2'b01:   count_q <= count_q - QCNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

@@ rtl/core/pbz_back.sv @@
// Back end: averages, threshold, tone sequencing and the output register.
// Depends on pbz_pkg; drains pbz_fifo one command per cycle unless a valid output is stalled.
`timescale 1ns / 1ps

module pbz_back
	import pbz_pkg::*;
#(
	parameter int AVG_SAMPLES = AVG_SAMPLES_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  cfg_t             cfg,
	input  logic             head_valid,
	input  cmd_t             head_cmd,
	output logic             pop,
	output logic             out_valid,
	input  logic             out_stall,
	output logic             buzzer_on,
	output logic             in_setting,
	output logic [AVG_W-1:0] shown_value,
	output logic             average_ready
);

	// divide by AVG_SAMPLES as multiply by a rounded-up reciprocal; exact for 16-bit sums
	localparam int DIV_SHIFT = SUM_W + $clog2(AVG_SAMPLES);
	localparam int DIV_MULT  = ((1 << DIV_SHIFT) + AVG_SAMPLES - 1) / AVG_SAMPLES;
	localparam int MULT_W    = $clog2(DIV_MULT + 1);
	localparam int PROD_W    = SUM_W + MULT_W;

	logic [THR_W-1:0]   thr_q;
	logic [AVG_W-1:0]   avg_q;
	logic [1:0]         ph_q;
	logic [TIMER_W-1:0] tmr_q;
	logic               lvl_q;
	logic               out_valid_q;

	logic [THR_W-1:0]   thr_n;
	logic [AVG_W-1:0]   avg_n;
	logic [1:0]         ph_n;
	logic [TIMER_W-1:0] tmr_n;
	logic               lvl_n;
	logic               rdy_n;

	logic [MULT_W-1:0]  mult_c;
	logic [PROD_W-1:0]  prod;
	logic [SUM_W-1:0]   quot;
	logic [AVG_W-1:0]   avg_sat;
	logic [THR_W-1:0]   thr_dn;
	logic [THR_W-1:0]   thr_up;
	logic [TIMER_W-1:0] tmr_dec;
	logic [TIMER_W-1:0] beep_len;
	logic [TIMER_W-1:0] gap_len;
	logic               beeping;
	logic               adv;

	assign adv = !out_valid_q || !out_stall;
	assign pop = adv && head_valid;

	assign mult_c  = MULT_W'(DIV_MULT);
	assign prod    = PROD_W'(head_cmd.sum) * PROD_W'(mult_c);
	assign quot    = SUM_W'(prod >> DIV_SHIFT);
	assign avg_sat = (quot > SUM_W'(AVG_MAX)) ? AVG_MAX : quot[AVG_W-1:0];

	assign thr_dn = (head_cmd.left && thr_q != '0) ? thr_q - THR_W'(1) : thr_q;
	assign thr_up = (head_cmd.right && thr_dn < THRESH_MAX) ? thr_dn + THR_W'(1) : thr_dn;

	// zero-length phases run for one tick
	assign beep_len = (cfg.beep_on == '0) ? TIMER_W'(1) : TIMER_W'(cfg.beep_on);
	assign gap_len  = (avg_q == '0) ? TIMER_W'(1) : TIMER_W'(avg_q);
	assign tmr_dec  = (tmr_q != '0) ? tmr_q - TIMER_W'(1) : '0;
	assign beeping  = (ph_q == PH_ON) || (ph_q == PH_OFF);

	always_comb begin
		thr_n = thr_q;
		avg_n = avg_q;
		ph_n  = ph_q;
		tmr_n = tmr_q;
		lvl_n = lvl_q;
		rdy_n = 1'b0;
		case (head_cmd.kind)
			CMD_AVG: begin
				avg_n = avg_sat;
				rdy_n = 1'b1;
				if (!head_cmd.enable) begin
					ph_n  = PH_SILENT;
					lvl_n = 1'b0;
				end else if (avg_sat != '0 && avg_sat <= AVG_W'(thr_q)) begin
					ph_n  = PH_STEADY;
					lvl_n = 1'b1;
				end else if (avg_sat > AVG_W'(thr_q) && avg_sat <= cfg.far_limit) begin
					if (!beeping) begin
						ph_n  = PH_ON;
						tmr_n = beep_len;
						lvl_n = 1'b1;
					end
				end else begin
					ph_n  = PH_SILENT;
					lvl_n = 1'b0;
				end
			end
			CMD_ROT: begin
				if (head_cmd.setting) begin
					thr_n = thr_up;
				end
			end
			CMD_TICK: begin
				if (beeping) begin
					if (tmr_dec != '0) begin
						tmr_n = tmr_dec;
					end else if (ph_q == PH_ON) begin
						ph_n  = PH_OFF;
						tmr_n = gap_len;
						lvl_n = 1'b0;
					end else begin
						ph_n  = PH_ON;
						tmr_n = beep_len;
						lvl_n = 1'b1;
					end
				end
			end
			default: begin
				thr_n = thr_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q       <= THRESH_RESET;
			avg_q       <= '0;
			ph_q        <= PH_SILENT;
			tmr_q       <= '0;
			lvl_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= head_valid;
			if (head_valid) begin
				thr_q <= thr_n;
				avg_q <= avg_n;
				ph_q  <= ph_n;
				tmr_q <= tmr_n;
				lvl_q <= lvl_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			buzzer_on     <= lvl_n;
			in_setting    <= head_cmd.setting;
			shown_value   <= head_cmd.setting ? AVG_W'(thr_n) : avg_n;
			average_ready <= rdy_n;
		end
	end

	assign out_valid = out_valid_q;

endmodule

@@ rtl/core/parking_distance_buzzer_top.sv @@
// Top level of the parking distance buzzer: APB registers and the front/queue/back chain.
// Depends on pbz_pkg, pbz_front, pbz_fifo and pbz_back.
//
//   Channel  Direction  Handshake            Payload
//   -------  ---------  -------------------  -----------------------------------------------
//   in       input      in_valid / in_stall  mode, sample_cm, rot_press/left/right, enable
//   out      output     out_valid / out_stall buzzer_on, in_setting, shown_value, average_ready
//   cfg      input      APB psel/penable     paddr 0: far_limit_cm, paddr 4: beep_on_ms
//
// One word per cycle in and out when nothing stalls. A word is written into the
// four-entry queue and, once popped, into the output register; the back end computes
// its state update (reciprocal multiply, compare, timer step) combinationally from the head.
// Reset is asynchronous, active low, and restores the default registers and threshold 40.
// An output stall holds the result and the queue; in_stall rises only when the queue is full.
`timescale 1ns / 1ps

module parking_distance_buzzer_top
	import pbz_pkg::*;
#(
	parameter int AVG_SAMPLES = AVG_SAMPLES_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [1:0]          mode,
	input  logic [SAMPLE_W-1:0] sample_cm,
	input  logic                rot_press,
	input  logic                rot_left,
	input  logic                rot_right,
	input  logic                buzzer_enable,
	output logic                out_valid,
	input  logic                out_stall,
	output logic                buzzer_on,
	output logic                in_setting,
	output logic [AVG_W-1:0]    shown_value,
	output logic                average_ready,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [2:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready
);

	cfg_t cfg_q;
	logic cfg_wr;

	logic q_full;
	logic push;
	cmd_t push_cmd;
	logic pop;
	logic head_valid;
	cmd_t head_cmd;

	// APB: no wait states; register index is paddr[2]
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.far_limit <= FAR_RESET;
			cfg_q.beep_on   <= BEEP_RESET;
		end else if (cfg_wr) begin
			case (paddr[2])
				REG_FAR:  cfg_q.far_limit <= pwdata[AVG_W-1:0];
				REG_BEEP: cfg_q.beep_on   <= pwdata[BEEP_W-1:0];
				default:  cfg_q           <= cfg_q;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_FAR:  prdata = {{(32-AVG_W){1'b0}}, cfg_q.far_limit};
			REG_BEEP: prdata = {{(32-BEEP_W){1'b0}}, cfg_q.beep_on};
			default:  prdata = '0;
		endcase
	end

	// front: decode each word, keep mode and the partial sample sum
	pbz_front #(
		.AVG_SAMPLES (AVG_SAMPLES)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.mode          (mode),
		.sample_cm     (sample_cm),
		.rot_press     (rot_press),
		.rot_left      (rot_left),
		.rot_right     (rot_right),
		.buzzer_enable (buzzer_enable),
		.q_full        (q_full),
		.push          (push),
		.push_cmd      (push_cmd)
	);

	// queue: decouple front acceptance from back-pressure on the output
	pbz_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_cmd   (push_cmd),
		.full       (q_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_cmd   (head_cmd)
	);

	// back: average, threshold and tone state, then the output register
	pbz_back #(
		.AVG_SAMPLES (AVG_SAMPLES)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg_q),
		.head_valid    (head_valid),
		.head_cmd      (head_cmd),
		.pop           (pop),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.buzzer_on     (buzzer_on),
		.in_setting    (in_setting),
		.shown_value   (shown_value),
		.average_ready (average_ready)
	);

endmodule
